// ===== hdl/crf_pkg.sv =====
// shared types, frame constants and crc helper for the command reply framer
// no dependencies; used by every module of the block
package crf_pkg;

    // config port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_VERSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_STATUS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRMWARE_VERSION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_REPLY_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_REPLY_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_REPLY_CODE = 3'd5;

    // command codes
    localparam logic [7:0] CMD_STATUS = 8'h20;
    localparam logic [7:0] CMD_START  = 8'h10;
    localparam logic [7:0] CMD_STOP   = 8'h11;
    localparam logic [7:0] CMD_POWER  = 8'h30;

    // frame bytes
    localparam logic [7:0] SYNC_A      = 8'hAA;
    localparam logic [7:0] SYNC_B      = 8'h55;
    localparam logic [7:0] STATUS_LEN  = 8'h05;
    localparam logic [7:0] STATUS_TYPE = 8'hA0;
    localparam logic [7:0] ACK_LEN     = 8'h03;
    localparam logic [7:0] ACK_TYPE    = 8'h90;

    // byte position of the final crc byte
    localparam logic [3:0] STATUS_LAST = 4'd11;
    localparam logic [3:0] ACK_LAST    = 4'd9;
    // first byte covered by the crc
    localparam logic [3:0] CRC_FIRST   = 4'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [7:0]  ready_status;
        logic [15:0] firmware_version;
        logic [7:0]  start_reply_code;
        logic [7:0]  stop_reply_code;
        logic [7:0]  power_reply_code;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic [7:0] seq;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } beat_t;

    // crc-16/ccitt-false update by one byte, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // code produces a reply frame
    function automatic logic cmd_known(input logic [7:0] code);
        return (code == CMD_STATUS) || (code == CMD_START) ||
               (code == CMD_STOP) || (code == CMD_POWER);
    endfunction

endpackage

// ===== hdl/crf_frame_seq.sv =====
// reply frame sequencer: holds one command, walks its bytes and runs the crc
// depends on crf_pkg
module crf_frame_seq
(
    input  logic          clk,
    input  logic          rst_n,
    input  crf_pkg::cfg_t cfg,
    input  crf_pkg::cmd_t pend,
    input  logic          advance,
    output logic          take,
    output crf_pkg::beat_t beat
);

    logic        active_reg, active_next;
    logic [3:0]  idx_reg, idx_next;
    logic        is_status_reg;
    logic [7:0]  code_reg;
    logic [7:0]  seq_reg;
    logic [15:0] crc_reg, crc_next;

    logic [3:0]  last_idx;
    logic        at_last;
    logic        emit;
    logic        crc_upd;
    logic [7:0]  result_byte;
    logic [7:0]  byte_sel;

    // byte position control and crc
    always_comb
    begin
        last_idx = is_status_reg ? crf_pkg::STATUS_LAST : crf_pkg::ACK_LAST;
        at_last  = (idx_reg == last_idx);
        emit     = active_reg && advance;
        take     = pend.valid && (!active_reg || (emit && at_last));
        crc_upd  = emit && (idx_reg >= crf_pkg::CRC_FIRST) &&
                   (idx_reg <= (last_idx - 4'd2));

        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (take)
        begin
            active_next = crf_pkg::cmd_known(pend.code);
            idx_next    = 4'd0;
            crc_next    = crf_pkg::CRC_INIT;
        end
        else if (emit)
        begin
            active_next = !at_last;
            idx_next    = idx_reg + 4'd1;
            if (crc_upd)
            begin
                crc_next = crf_pkg::crc16_byte(crc_reg, byte_sel);
            end
        end
    end

    // ack result byte by command
    always_comb
    begin
        case (code_reg)
            crf_pkg::CMD_START: result_byte = cfg.start_reply_code;
            crf_pkg::CMD_STOP:  result_byte = cfg.stop_reply_code;
            default:            result_byte = cfg.power_reply_code;
        endcase
    end

    // frame byte at the current position
    always_comb
    begin
        case (idx_reg)
            4'd0:    byte_sel = crf_pkg::SYNC_A;
            4'd1:    byte_sel = crf_pkg::SYNC_B;
            4'd2:    byte_sel = is_status_reg ? crf_pkg::STATUS_LEN : crf_pkg::ACK_LEN;
            4'd3:    byte_sel = is_status_reg ? crf_pkg::STATUS_TYPE : crf_pkg::ACK_TYPE;
            4'd4:    byte_sel = seq_reg;
            4'd5:    byte_sel = is_status_reg ? cfg.protocol_version : code_reg;
            4'd6:    byte_sel = is_status_reg ? cfg.ready_status : seq_reg;
            4'd7:    byte_sel = is_status_reg ? cfg.firmware_version[7:0] : result_byte;
            4'd8:    byte_sel = is_status_reg ? cfg.firmware_version[15:8] : crc_reg[7:0];
            4'd9:    byte_sel = is_status_reg ? seq_reg : crc_reg[15:8];
            4'd10:   byte_sel = crc_reg[7:0];
            4'd11:   byte_sel = crc_reg[15:8];
            default: byte_sel = 8'h00;
        endcase
    end

    assign beat.valid = emit;
    assign beat.data  = byte_sel;
    assign beat.last  = at_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 4'd0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    // command payload and crc
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (take)
        begin
            is_status_reg <= (pend.code == crf_pkg::CMD_STATUS);
            code_reg      <= pend.code;
            seq_reg       <= pend.seq;
        end
    end

endmodule

// ===== hdl/crf_out_stage.sv =====
// output register for reply bytes, holds a byte while the receiver stalls
// depends on crf_pkg
module crf_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  crf_pkg::beat_t beat,
    input  logic           out_stall,
    output logic           advance,
    output logic           out_valid,
    output logic [7:0]     frame_byte,
    output logic           last_of_frame
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // register free or being emptied this cycle
    assign advance = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && beat.valid)
        begin
            byte_reg <= beat.data;
            last_reg <= beat.last;
        end
    end

    assign out_valid     = valid_reg;
    assign frame_byte    = byte_reg;
    assign last_of_frame = last_reg;

endmodule

// ===== hdl/command_reply_framer_crc16_core.sv =====
// top level of the command reply framer: config registers, command register, sequencer, output register
// depends on crf_pkg, crf_frame_seq, crf_out_stage
//
// channel | signals                                   | direction
// in      | in_valid, in_stall, command_code, seq num | command transaction in
// out     | out_valid, out_stall, frame_byte, last    | one reply byte per transaction
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// a status command gives 12 bytes, an acknowledge 10, one byte per cycle
// out of the sequencer while out_stall does not hold the output register.
// an unknown code is taken by the sequencer and gives no bytes.
// a command waits in the command register while a frame is sent; in_stall
// is high while that register is full. out_stall holds the output register.
// reset clears all transactions in flight and loads the register defaults.
module command_reply_framer_crc16_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       command_code,
    input  logic [7:0]                       sequence_number,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       frame_byte,
    output logic                             last_of_frame,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    crf_pkg::cfg_t  cfg_reg;
    crf_pkg::cmd_t  pend;
    crf_pkg::beat_t beat;

    logic       pend_valid_reg;
    logic [7:0] pend_code_reg;
    logic [7:0] pend_seq_reg;
    logic       pend_take;
    logic       advance;
    logic       in_accept;
    logic       cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.protocol_version <= 8'd1;
            cfg_reg.ready_status     <= 8'd2;
            cfg_reg.firmware_version <= 16'd1;
            cfg_reg.start_reply_code <= 8'd0;
            cfg_reg.stop_reply_code  <= 8'd0;
            cfg_reg.power_reply_code <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                crf_pkg::REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= cfg_data[7:0];
                crf_pkg::REG_READY_STATUS:     cfg_reg.ready_status     <= cfg_data[7:0];
                crf_pkg::REG_FIRMWARE_VERSION: cfg_reg.firmware_version <= cfg_data;
                crf_pkg::REG_START_REPLY_CODE: cfg_reg.start_reply_code <= cfg_data[7:0];
                crf_pkg::REG_STOP_REPLY_CODE:  cfg_reg.stop_reply_code  <= cfg_data[7:0];
                crf_pkg::REG_POWER_REPLY_CODE: cfg_reg.power_reply_code <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // command register
    assign in_stall  = pend_valid_reg;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_take)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_code_reg <= command_code;
            pend_seq_reg  <= sequence_number;
        end
    end

    assign pend.valid = pend_valid_reg;
    assign pend.code  = pend_code_reg;
    assign pend.seq   = pend_seq_reg;

    // frame sequencer
    crf_frame_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .pend    (pend),
        .advance (advance),
        .take    (pend_take),
        .beat    (beat)
    );

    // output register
    crf_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .beat          (beat),
        .out_stall     (out_stall),
        .advance       (advance),
        .out_valid     (out_valid),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame)
    );

`ifndef SYNTHESIS
    // an accepted command is held until the sequencer takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !pend_take |=> pend_valid_reg && $stable(pend_code_reg))
        else $error("pending command lost or changed before take");

    // the sequencer only takes a command that is present
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_take |-> pend_valid_reg)
        else $error("command taken from empty register");

    // a byte is only produced while the output register can load it
    assert property (@(posedge clk) disable iff (!rst_n)
        beat.valid |-> advance)
        else $error("byte produced while output register is blocked");

    // a firmware version write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == crf_pkg::REG_FIRMWARE_VERSION)
        |=> cfg_reg.firmware_version == $past(cfg_data))
        else $error("firmware version write not applied");
`endif

endmodule

// ===== test/command_reply_framer_crc16_checker.sv =====
// reply checker for the command reply framer: predicts every reply byte and compares
// depends on crf_pkg for command codes, register indexes, frame bytes and cfg_t
`timescale 1ns / 1ps

module command_reply_framer_crc16_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     command_code,
    input  logic [7:0]                     sequence_number,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [7:0]                     frame_byte,
    input  logic                           last_of_frame,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             bytes_outstanding
);

    localparam logic [7:0]  PROTOCOL_VERSION_DEFAULT = 8'd1;
    localparam logic [7:0]  READY_STATUS_DEFAULT     = 8'd2;
    localparam logic [15:0] FIRMWARE_VERSION_DEFAULT = 16'd1;
    localparam logic [7:0]  REPLY_CODE_DEFAULT       = 8'd0;
    localparam int          STATUS_FRAME_LEN         = 12;
    localparam int          ACK_FRAME_LEN            = 10;
    localparam int          REPORT_LIMIT             = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } reply_byte_t;

    reply_byte_t     replies_due[$];
    reply_byte_t     head;
    crf_pkg::cfg_t   regs;
    int              failures = 0;

    // crc-16/ccitt-false, one data bit at a time, msb first
    function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc,
                                                     input logic [7:0]  value);
        logic [15:0] acc;
        logic        feedback;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = acc[15] ^ value[i];
            acc      = {acc[14:0], 1'b0};
            if (feedback)
            begin
                acc = acc ^ crf_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    // build the reply frame for one command and queue its bytes
    task automatic queue_reply(input logic [7:0] code, input logic [7:0] seq);
        logic [7:0]  frame [STATUS_FRAME_LEN];
        logic [15:0] crc;
        int          len;
        len      = 0;
        frame[0] = crf_pkg::SYNC_A;
        frame[1] = crf_pkg::SYNC_B;
        frame[4] = seq;
        if (code == crf_pkg::CMD_STATUS)
        begin
            frame[2] = crf_pkg::STATUS_LEN;
            frame[3] = crf_pkg::STATUS_TYPE;
            frame[5] = regs.protocol_version;
            frame[6] = regs.ready_status;
            frame[7] = regs.firmware_version[7:0];
            frame[8] = regs.firmware_version[15:8];
            frame[9] = seq;
            len      = STATUS_FRAME_LEN;
        end
        else if (code == crf_pkg::CMD_START || code == crf_pkg::CMD_STOP ||
                 code == crf_pkg::CMD_POWER)
        begin
            frame[2] = crf_pkg::ACK_LEN;
            frame[3] = crf_pkg::ACK_TYPE;
            frame[5] = code;
            frame[6] = seq;
            if (code == crf_pkg::CMD_START)
            begin
                frame[7] = regs.start_reply_code;
            end
            else if (code == crf_pkg::CMD_STOP)
            begin
                frame[7] = regs.stop_reply_code;
            end
            else
            begin
                frame[7] = regs.power_reply_code;
            end
            len = ACK_FRAME_LEN;
        end
        // unknown codes give no reply at all
        if (len != 0)
        begin
            crc = crf_pkg::CRC_INIT;
            for (int k = 2; k < len - 2; k++)
            begin
                crc = crc_ccitt_update(crc, frame[k]);
            end
            frame[len-2] = crc[7:0];
            frame[len-1] = crc[15:8];
            for (int k = 0; k < len; k++)
            begin
                replies_due.push_back('{value: frame[k], last: (k == len - 1)});
            end
        end
    endtask

    // watch all three channels; outputs are checked before new commands queue up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.protocol_version = PROTOCOL_VERSION_DEFAULT;
            regs.ready_status     = READY_STATUS_DEFAULT;
            regs.firmware_version = FIRMWARE_VERSION_DEFAULT;
            regs.start_reply_code = REPLY_CODE_DEFAULT;
            regs.stop_reply_code  = REPLY_CODE_DEFAULT;
            regs.power_reply_code = REPLY_CODE_DEFAULT;
            replies_due.delete();
            mismatch_count    <= failures;
            bytes_outstanding <= 0;
        end
        else
        begin
            // reply byte transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                    begin
                        $display("%m: unexpected reply byte %02h last %0b",
                                 frame_byte, last_of_frame);
                    end
                end
                else
                begin
                    head = replies_due.pop_front();
                    if (frame_byte !== head.value || last_of_frame !== head.last)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                        begin
                            $display({"%m: reply byte mismatch: ",
                                      "expected %02h last %0b, got %02h last %0b"},
                                     head.value, head.last, frame_byte, last_of_frame);
                        end
                    end
                end
            end

            // register write, upper data bits dropped for 8-bit registers
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    crf_pkg::REG_PROTOCOL_VERSION: regs.protocol_version = cfg_data[7:0];
                    crf_pkg::REG_READY_STATUS:     regs.ready_status     = cfg_data[7:0];
                    crf_pkg::REG_FIRMWARE_VERSION: regs.firmware_version = cfg_data[15:0];
                    crf_pkg::REG_START_REPLY_CODE: regs.start_reply_code = cfg_data[7:0];
                    crf_pkg::REG_STOP_REPLY_CODE:  regs.stop_reply_code  = cfg_data[7:0];
                    crf_pkg::REG_POWER_REPLY_CODE: regs.power_reply_code = cfg_data[7:0];
                    default:                       ;
                endcase
            end

            // command transaction
            if (in_valid && !in_stall)
            begin
                queue_reply(command_code, sequence_number);
            end

            mismatch_count    <= failures;
            bytes_outstanding <= replies_due.size();
        end
    end

endmodule

// ===== test/command_reply_framer_crc16_core_tb.sv =====
// testbench top for the command reply framer: clock, reset, stimulus and verdict
// depends on crf_pkg, command_reply_framer_crc16_core and command_reply_framer_crc16_checker
`timescale 1ns / 1ps

module command_reply_framer_crc16_core_tb;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          RANDOM_PHASES   = 4;
    localparam int          ITEMS_PER_PHASE = 90;
    // indexes past the register list, writes there are dropped
    localparam logic [crf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [crf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                           clk             = 1'b0;
    logic                           rst_n           = 1'b0;
    logic                           in_valid        = 1'b0;
    logic                           in_stall;
    logic [7:0]                     command_code    = 8'h00;
    logic [7:0]                     sequence_number = 8'h00;
    logic                           out_valid;
    logic                           out_stall       = 1'b0;
    logic [7:0]                     frame_byte;
    logic                           last_of_frame;
    logic                           cfg_valid       = 1'b0;
    logic                           cfg_ready;
    logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [crf_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

    int          mismatches;
    int          outstanding;
    int          idle_pct = 0;
    int unsigned cycles   = 0;

    command_reply_framer_crc16_core u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command_code    (command_code),
        .sequence_number (sequence_number),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_byte      (frame_byte),
        .last_of_frame   (last_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    command_reply_framer_crc16_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command_code      (command_code),
        .sequence_number   (sequence_number),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_byte        (frame_byte),
        .last_of_frame     (last_of_frame),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatch_count    (mismatches),
        .bytes_outstanding (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("command_reply_framer_crc16_core_tb: FAIL");
            $finish;
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // one command transaction, maybe after an idle burst; valid stays high after
    task automatic send_command(input logic [7:0] code, input logic [7:0] seq);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command_code    <= code;
        sequence_number <= seq;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every outstanding reply byte, then settle
    task automatic wait_for_replies(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // one register write transaction; valid stays high after
    task automatic write_reg(input logic [crf_pkg::CFG_IDX_W-1:0]  index,
                             input logic [crf_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    // write every register, junk in the unused upper bits, plus the spare indexes
    task automatic program_regs(input logic [7:0]  proto,
                                input logic [7:0]  ready,
                                input logic [15:0] firmware,
                                input logic [7:0]  start_code,
                                input logic [7:0]  stop_code,
                                input logic [7:0]  power_code);
        write_reg(crf_pkg::REG_PROTOCOL_VERSION, {8'($urandom), proto});
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(crf_pkg::REG_READY_STATUS, {8'($urandom), ready});
        write_reg(crf_pkg::REG_FIRMWARE_VERSION, firmware);
        write_reg(crf_pkg::REG_START_REPLY_CODE, {8'($urandom), start_code});
        write_reg(crf_pkg::REG_STOP_REPLY_CODE, {8'($urandom), stop_code});
        write_reg(REG_SPARE_HI, 16'($urandom));
        write_reg(crf_pkg::REG_POWER_REPLY_CODE, {8'($urandom), power_code});
        cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        logic [7:0] code;
        int         pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register reset values, sequence extremes, unknown codes around the known ones
        idle_pct = 30;
        send_command(crf_pkg::CMD_STATUS, 8'h00);
        send_command(crf_pkg::CMD_STATUS, 8'hFF);
        send_command(crf_pkg::CMD_START, 8'h00);
        send_command(crf_pkg::CMD_STOP, 8'hFF);
        send_command(crf_pkg::CMD_POWER, 8'h5A);
        send_command(8'h00, 8'h33);
        send_command(8'hFF, 8'hCC);
        send_command(crf_pkg::CMD_START - 8'd1, 8'h01);
        send_command(crf_pkg::CMD_STOP + 8'd1, 8'h80);
        send_command(crf_pkg::CMD_STATUS + 8'd1, 8'h7F);
        send_command(crf_pkg::CMD_POWER + 8'd1, 8'hFE);
        wait_for_replies(SETTLE_CYCLES);

        // all registers at their top value
        program_regs(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_command(crf_pkg::CMD_STATUS, 8'hA5);
        send_command(crf_pkg::CMD_START, 8'hFF);
        send_command(crf_pkg::CMD_STOP, 8'h00);
        send_command(crf_pkg::CMD_POWER, 8'hFF);
        wait_for_replies(SETTLE_CYCLES);

        // all registers at zero
        program_regs(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00);
        send_command(crf_pkg::CMD_STATUS, 8'h5A);
        send_command(crf_pkg::CMD_POWER, 8'h00);
        send_command(crf_pkg::CMD_STOP, 8'hFF);
        send_command(crf_pkg::CMD_START, 8'h81);

        // random phases, each with fresh register values; the last one never idles
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_replies(SETTLE_CYCLES);
            program_regs(8'($urandom), 8'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
            case (phase)
                0:       idle_pct = 30;
                1:       idle_pct = 60;
                2:       idle_pct = 15;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1:    code = crf_pkg::CMD_STATUS;
                    2, 3:    code = crf_pkg::CMD_START;
                    4:       code = crf_pkg::CMD_STOP;
                    5, 6:    code = crf_pkg::CMD_POWER;
                    default: code = 8'($urandom);
                endcase
                send_command(code, 8'($urandom));
                // halfway through each phase but the last, the sender holds off until the framer has drained
                if (i == ITEMS_PER_PHASE / 2 && phase != RANDOM_PHASES - 1)
                begin
                    wait_for_replies(0);
                end
            end
        end

        wait_for_replies(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("command_reply_framer_crc16_core_tb: PASS");
        end
        else
        begin
            $display("command_reply_framer_crc16_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/crf_pkg.sv
hdl/crf_frame_seq.sv
hdl/crf_out_stage.sv
hdl/command_reply_framer_crc16_core.sv
test/command_reply_framer_crc16_checker.sv
test/command_reply_framer_crc16_core_tb.sv
